### hw/rtl/swm2d_pkg.sv
// ----------------------------------------------------------------------------
// swm2d_pkg
// shared constants, types and helpers of the 2d sliding window maximum filter
// ----------------------------------------------------------------------------
package swm2d_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WIN_W  = 16;
    localparam int MAX_WIN_H  = 16;
    localparam int PIXEL_BITS = 16;

    // stored pixel width, the port carries 16 bits
    localparam int PIX_W = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

    // row window taps and line store rows, at least one of each
    localparam int RW_DEPTH = (MAX_WIN_W > 1) ? MAX_WIN_W - 1 : 1;
    localparam int LS_ROWS  = (MAX_WIN_H > 1) ? MAX_WIN_H - 1 : 1;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IW_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW_W  = $clog2(MAX_WIN_W + 1);
    localparam int WH_W  = $clog2(MAX_WIN_H + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WIN_WIDTH    = 2'd2,
        CFG_WIN_HEIGHT   = 2'd3
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // one line store entry: horizontal maxima of the previous rows at a column,
    // word 0 is the row just above
    typedef logic [LS_ROWS-1:0][PIX_W-1:0] line_entry_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             row_last;
        logic             frame_last;
        logic [COL_W-1:0] col;
    } stage_ctrl_t;

    typedef struct packed {
        logic [15:0] max_value;
        logic        row_last;
        logic        frame_last;
    } out_item_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

### hw/rtl/swm2d_ram.sv
// ----------------------------------------------------------------------------
// swm2d_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module swm2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/swm2d_hmax.sv
// ----------------------------------------------------------------------------
// swm2d_hmax
// row window shift line and horizontal maximum over the last win_width pixels
// ----------------------------------------------------------------------------
module swm2d_hmax (
    input  logic                         aclk,
    input  logic                         shift_en,
    input  swm2d_pkg::pix_t              pixel,
    input  logic [swm2d_pkg::WW_W-1:0]   win_width,
    output swm2d_pkg::pix_t              hmax
);
    import swm2d_pkg::*;

    localparam int N  = RW_DEPTH + 1;
    localparam int TN = 2 ** $clog2(N);

    pix_t window_reg [RW_DEPTH];
    pix_t node       [2*TN];

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            window_reg[0] <= pixel;
            for (int k = 1; k < RW_DEPTH; k++) begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    // balanced max tree, leaves outside the window read as zero
    always_comb begin
        for (int i = 0; i < 2*TN; i++) begin
            node[i] = '0;
        end
        node[TN] = pixel;
        for (int k = 0; k < RW_DEPTH; k++) begin
            node[TN+1+k] = (32'(k) + 32'd1 < 32'(win_width)) ? window_reg[k] : '0;
        end
        for (int i = TN - 1; i >= 1; i--) begin
            node[i] = max2(node[2*i], node[2*i+1]);
        end
        hmax = node[1];
    end

endmodule

### hw/rtl/swm2d_vmax.sv
// ----------------------------------------------------------------------------
// swm2d_vmax
// line store read-modify-write and vertical maximum over previous rows
// ----------------------------------------------------------------------------
module swm2d_vmax (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [swm2d_pkg::COL_W-1:0]   rd_addr,
    input  swm2d_pkg::stage_ctrl_t        s1_ctrl,
    input  swm2d_pkg::pix_t               s1_hmax,
    input  logic [swm2d_pkg::WH_W-1:0]    win_height,
    output swm2d_pkg::pix_t               vmax
);
    import swm2d_pkg::*;

    localparam int N  = LS_ROWS + 1;
    localparam int TN = 2 ** $clog2(N);

    line_entry_t rd_entry;
    line_entry_t entry;
    line_entry_t new_entry;
    line_entry_t fwd_data_reg;
    logic        fwd_hit_reg;
    pix_t        node [2*TN];

    swm2d_ram #(
        .WIDTH (LS_ROWS * PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_ctrl.valid),
        .wr_addr (s1_ctrl.col),
        .wr_data (new_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // same column read while its write-back lands: take the written entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= rd_en && s1_ctrl.valid && (rd_addr == s1_ctrl.col);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= new_entry;
    end

    assign entry = fwd_hit_reg ? fwd_data_reg : rd_entry;

    // age the column history by one row
    always_comb begin
        new_entry[0] = s1_hmax;
        for (int j = 1; j < LS_ROWS; j++) begin
            new_entry[j] = entry[j-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 2*TN; i++) begin
            node[i] = '0;
        end
        node[TN] = s1_hmax;
        for (int j = 0; j < LS_ROWS; j++) begin
            node[TN+1+j] = (32'(j) + 32'd1 < 32'(win_height)) ? entry[j] : '0;
        end
        for (int i = TN - 1; i >= 1; i--) begin
            node[i] = max2(node[2*i], node[2*i+1]);
        end
        vmax = node[1];
    end

endmodule

### hw/rtl/swm2d_out_fifo.sv
// ----------------------------------------------------------------------------
// swm2d_out_fifo
// small result queue that decouples the pipeline from the receiver
// ----------------------------------------------------------------------------
module swm2d_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  swm2d_pkg::out_item_t              push_item,
    input  logic                              pop,
    output swm2d_pkg::out_item_t              head,
    output logic                              not_empty,
    output logic [swm2d_pkg::FIFO_CNT_W-1:0]  count
);
    import swm2d_pkg::*;

    out_item_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### hw/rtl/sliding_window_max_2d.sv
// ----------------------------------------------------------------------------
// sliding_window_max_2d
// separable 2d sliding window maximum (grayscale dilation) over a pixel stream
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the s_ channel in raster order, one request per pixel.
//   for each pixel whose window (win_height rows by win_width columns, bottom
//   right at this pixel) lies inside the frame, one result request leaves on
//   the m_ channel with the window maximum and row / frame end flags.
//   pixels near the left or top edge give no result.
//   throughput: one pixel per clock while the result queue has room, set
//   by the line store, which is read and written back once per pixel over
//   its two ports. a result goes through stage 1 and the result queue to m_.
//   the receiver may stall at will: a three entry result queue absorbs the
//   pipeline, and s_ready drops when the queue plus the pixel in stage 1
//   leave no room for one more result.
//   configuration is written through cfg_wr_en / cfg_index / cfg_data while
//   the block is idle; any write restarts the frame at row 0, column 0.
//   reset restores 1024 x 1024 frames and a 3 x 3 window and starts a frame;
//   no clearing pass is needed, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module sliding_window_max_2d (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [swm2d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swm2d_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_pixel,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_max_value,
    output logic                               m_row_last,
    output logic                               m_frame_last
);
    import swm2d_pkg::*;

    // reset values, limited to the configured maxima
    localparam int IW_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int WW_RST = (MAX_WIN_W < 3) ? MAX_WIN_W : 3;
    localparam int WH_RST = (MAX_WIN_H < 3) ? MAX_WIN_H : 3;

    // configuration, held already clamped to the legal range
    logic [IW_W-1:0]   image_width_reg;
    logic [15:0]       image_height_reg;
    logic [WW_W-1:0]   win_width_reg;
    logic [WH_W-1:0]   win_height_reg;

    logic [10:0]       iw_raw;
    logic [15:0]       ih_raw;
    logic [4:0]        ww_raw;
    logic [4:0]        wh_raw;
    logic [IW_W-1:0]   iw_clamped;
    logic [15:0]       ih_clamped;
    logic [WW_W-1:0]   ww_clamped;
    logic [WH_W-1:0]   wh_clamped;

    // frame position
    logic [COL_W-1:0]  col_reg;
    logic [15:0]       row_reg;
    logic [COL_W-1:0]  col_next;
    logic [15:0]       row_next;
    logic              col_last;
    logic              row_last;
    logic              emit;

    logic              accept;
    pix_t              pixel;
    pix_t              hmax;
    pix_t              vmax;

    // stage 1: horizontal maximum and line store read data
    stage_ctrl_t       s1_ctrl_reg;
    pix_t              s1_hmax_reg;

    out_item_t                push_item;
    out_item_t                head;
    logic                     push;
    logic                     pop;
    logic                     fifo_not_empty;
    logic [FIFO_CNT_W-1:0]    fifo_count;

    // ------------------------------------------------------------------
    // configuration decode and clamping
    // ------------------------------------------------------------------
    assign iw_raw = cfg_data[10:0];
    assign ih_raw = cfg_data[15:0];
    assign ww_raw = cfg_data[4:0];
    assign wh_raw = cfg_data[4:0];

    // cut to field width, then zero means one and larger values saturate
    always_comb begin
        if (iw_raw == '0) begin
            iw_clamped = IW_W'(1);
        end else if (32'(iw_raw) > MAX_WIDTH) begin
            iw_clamped = IW_W'(MAX_WIDTH);
        end else begin
            iw_clamped = IW_W'(iw_raw);
        end
        ih_clamped = (ih_raw == '0) ? 16'd1 : ih_raw;
        if (ww_raw == '0) begin
            ww_clamped = WW_W'(1);
        end else if (32'(ww_raw) > MAX_WIN_W) begin
            ww_clamped = WW_W'(MAX_WIN_W);
        end else begin
            ww_clamped = WW_W'(ww_raw);
        end
        if (wh_raw == '0) begin
            wh_clamped = WH_W'(1);
        end else if (32'(wh_raw) > MAX_WIN_H) begin
            wh_clamped = WH_W'(MAX_WIN_H);
        end else begin
            wh_clamped = WH_W'(wh_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IW_W'(IW_RST);
            image_height_reg <= 16'd1024;
            win_width_reg    <= WW_W'(WW_RST);
            win_height_reg   <= WH_W'(WH_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= iw_clamped;
                CFG_IMAGE_HEIGHT: image_height_reg <= ih_clamped;
                CFG_WIN_WIDTH:    win_width_reg    <= ww_clamped;
                CFG_WIN_HEIGHT:   win_height_reg   <= wh_clamped;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input handshake and frame position
    // ------------------------------------------------------------------
    // room check counts the item in stage 1, which always moves on next clock
    assign s_ready = (32'(fifo_count) + 32'(s1_ctrl_reg.valid)) <= FIFO_DEPTH - 1;
    assign accept  = s_valid && s_ready;
    assign pixel   = s_pixel[PIX_W-1:0];

    assign col_last = (32'(col_reg) == 32'(image_width_reg) - 32'd1);
    assign row_last = (row_reg == image_height_reg - 16'd1);
    // window fully inside the frame
    assign emit = (32'(col_reg) + 32'd1 >= 32'(win_width_reg)) &&
                  (32'(row_reg) + 32'd1 >= 32'(win_height_reg));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? 16'd0 : row_reg + 16'd1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: row window and horizontal maximum, line store read issued
    // ------------------------------------------------------------------
    swm2d_hmax u_hmax (
        .aclk      (aclk),
        .shift_en  (accept),
        .pixel     (pixel),
        .win_width (win_width_reg),
        .hmax      (hmax)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg <= '0;
        end else begin
            s1_ctrl_reg.valid <= accept;
            if (accept) begin
                s1_ctrl_reg.emit       <= emit;
                s1_ctrl_reg.row_last   <= col_last;
                s1_ctrl_reg.frame_last <= col_last && row_last;
                s1_ctrl_reg.col        <= col_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_hmax_reg <= hmax;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: vertical maximum, line store write-back
    // ------------------------------------------------------------------
    swm2d_vmax u_vmax (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (accept),
        .rd_addr    (col_reg),
        .s1_ctrl    (s1_ctrl_reg),
        .s1_hmax    (s1_hmax_reg),
        .win_height (win_height_reg),
        .vmax       (vmax)
    );

    // ------------------------------------------------------------------
    // result queue and output channel
    // ------------------------------------------------------------------
    assign push                 = s1_ctrl_reg.valid && s1_ctrl_reg.emit;
    assign push_item.max_value  = 16'(vmax);
    assign push_item.row_last   = s1_ctrl_reg.row_last;
    assign push_item.frame_last = s1_ctrl_reg.frame_last;
    assign pop                  = fifo_not_empty && m_ready;

    swm2d_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (fifo_not_empty),
        .count     (fifo_count)
    );

    assign m_valid      = fifo_not_empty;
    assign m_max_value  = head.max_value;
    assign m_row_last   = head.row_last;
    assign m_frame_last = head.frame_last;

endmodule
